### design/prm_pkg.sv
// constants shared by the pump rpm / run-time alarm monitor
// register indexes, reset values and alarm bit positions; no dependencies
`timescale 1ns / 1ps

package prm_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;

  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned UPT_W   = 32;
  localparam int unsigned SHORT_W = 16;
  localparam int unsigned LONG_W  = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ALARM_W = 4;
  // signed width for deviation and limit-minus-hysteresis compares
  localparam int unsigned DEV_W   = SHORT_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_THRESHOLD  = 8'd0,
    REG_NOMINAL_RPM   = 8'd1,
    REG_DEV_TECHNICAL = 8'd2,
    REG_DEV_CRITICAL  = 8'd3,
    REG_HYSTERESIS    = 8'd4,
    REG_SPINUP        = 8'd5,
    REG_CYCLE_TECH    = 8'd6,
    REG_CYCLE_CRIT    = 8'd7
  } reg_idx_e;

  localparam logic [SHORT_W-1:0] ON_THRESHOLD_RST  = 16'd100;
  localparam logic [SHORT_W-1:0] NOMINAL_RPM_RST   = 16'd3000;
  localparam logic [SHORT_W-1:0] DEV_TECHNICAL_RST = 16'd300;
  localparam logic [SHORT_W-1:0] DEV_CRITICAL_RST  = 16'd600;
  localparam logic [SHORT_W-1:0] HYSTERESIS_RST    = 16'd50;
  localparam logic [LONG_W-1:0]  SPINUP_RST        = 32'd5000;
  localparam logic [LONG_W-1:0]  CYCLE_TECH_RST    = 32'd60000;
  localparam logic [LONG_W-1:0]  CYCLE_CRIT_RST    = 32'd120000;

  // alarm flag bit positions
  localparam int unsigned A_RPM_T = 0;
  localparam int unsigned A_RPM_C = 1;
  localparam int unsigned A_CYC_T = 2;
  localparam int unsigned A_CYC_C = 3;

endpackage

### design/pump_rpm_runtime_alarm_monitor.sv
// pump rpm / run-time alarm monitor top level
// input register, single-pass update and alarm logic, result register; uses prm_pkg
`timescale 1ns / 1ps

// Takes one sample per cycle (voltage, rpm, millisecond time) unless stalled,
// and returns one result item per sample. The sample is captured in an input
// register, and the run-state update plus alarm check are done in one pass of
// compare/subtract logic into the result register. The run state and alarm
// flags advance when an item moves from the input register to the result
// register, so a new sample can follow every cycle unless stalled; the input
// register still takes one item while a result waits on out_ready_i. Uptime is
// computed modulo 2^TIME_WIDTH and reported as its low 32 bits. Configuration
// registers are written through the cfg port, which is always ready; write them
// only while the block is idle. Indexes beyond the register list are ignored.
module pump_rpm_runtime_alarm_monitor #(
  parameter int unsigned TIME_WIDTH = prm_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [prm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [prm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // sample channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [prm_pkg::VOLT_W-1:0]       voltage_mv_i,
  input  logic [prm_pkg::RPM_W-1:0]        rpm_i,
  input  logic [prm_pkg::NOW_W-1:0]        now_ms_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             running_o,
  output logic [prm_pkg::UPT_W-1:0]        uptime_ms_o,
  output logic                             rpm_technical_alarm_o,
  output logic                             rpm_critical_alarm_o,
  output logic                             cycle_technical_alarm_o,
  output logic                             cycle_critical_alarm_o
);
  import prm_pkg::*;

  localparam int unsigned CMP_W = (TIME_WIDTH > LONG_W) ? TIME_WIDTH : LONG_W;

  // configuration registers
  logic [SHORT_W-1:0] on_thr_q, nominal_q, lim_t_q, lim_c_q, hyst_q;
  logic [LONG_W-1:0]  spinup_q, cyc_t_q, cyc_c_q;

  // input register
  logic                  in_valid_q;
  logic [VOLT_W-1:0]     volt_q;
  logic [RPM_W-1:0]      rpm_q;
  logic [TIME_WIDTH-1:0] now_q;

  // run state
  logic                  pump_on_q, pump_on_d;
  logic [TIME_WIDTH-1:0] start_q, start_d;
  logic [ALARM_W-1:0]    alarm_q, alarm_d;

  // result register
  logic                  out_valid_q;
  logic                  running_q;
  logic [UPT_W-1:0]      uptime_q;
  logic [ALARM_W-1:0]    out_alarm_q;

  logic                  advance;
  logic                  step;
  logic [TIME_WIDTH-1:0] uptime;
  logic [CMP_W-1:0]      uptime_x;
  logic signed [DEV_W-1:0] diff, dev, thr_t, thr_c;
  logic                  over_t, over_c;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign step        = advance && in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_thr_q  <= ON_THRESHOLD_RST;
      nominal_q <= NOMINAL_RPM_RST;
      lim_t_q   <= DEV_TECHNICAL_RST;
      lim_c_q   <= DEV_CRITICAL_RST;
      hyst_q    <= HYSTERESIS_RST;
      spinup_q  <= SPINUP_RST;
      cyc_t_q   <= CYCLE_TECH_RST;
      cyc_c_q   <= CYCLE_CRIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ON_THRESHOLD:  on_thr_q  <= cfg_data_i[SHORT_W-1:0];
        REG_NOMINAL_RPM:   nominal_q <= cfg_data_i[SHORT_W-1:0];
        REG_DEV_TECHNICAL: lim_t_q   <= cfg_data_i[SHORT_W-1:0];
        REG_DEV_CRITICAL:  lim_c_q   <= cfg_data_i[SHORT_W-1:0];
        REG_HYSTERESIS:    hyst_q    <= cfg_data_i[SHORT_W-1:0];
        REG_SPINUP:        spinup_q  <= cfg_data_i[LONG_W-1:0];
        REG_CYCLE_TECH:    cyc_t_q   <= cfg_data_i[LONG_W-1:0];
        REG_CYCLE_CRIT:    cyc_c_q   <= cfg_data_i[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      volt_q <= voltage_mv_i;
      rpm_q  <= rpm_i;
      now_q  <= TIME_WIDTH'(now_ms_i);
    end
  end

  always_comb begin
    pump_on_d = volt_q > on_thr_q;
    // start time latches on the rising edge of the run state
    if (!pump_on_d) begin
      start_d = '0;
    end else if (pump_on_q) begin
      start_d = start_q;
    end else begin
      start_d = now_q;
    end
    uptime   = pump_on_d ? (now_q - start_d) : '0;
    uptime_x = CMP_W'(uptime);

    diff   = signed'(DEV_W'(rpm_q)) - signed'(DEV_W'(nominal_q));
    dev    = (diff < 0) ? -diff : diff;
    thr_t  = signed'(DEV_W'(lim_t_q)) - signed'(DEV_W'(hyst_q));
    thr_c  = signed'(DEV_W'(lim_c_q)) - signed'(DEV_W'(hyst_q));
    over_t = dev >= signed'(DEV_W'(lim_t_q));
    over_c = dev >= signed'(DEV_W'(lim_c_q));

    alarm_d = alarm_q;
    if (!pump_on_d || (uptime_x < CMP_W'(spinup_q))) begin
      alarm_d = '0;
    end else begin
      priority if (over_c) begin
        alarm_d[A_RPM_C] = 1'b1;
      end else if (alarm_q[A_RPM_C] && (dev < thr_c)) begin
        alarm_d[A_RPM_C] = 1'b0;
      end else if (over_t && !alarm_q[A_RPM_T]) begin
        alarm_d[A_RPM_T] = 1'b1;
      end else if (!over_t && alarm_q[A_RPM_T] && (dev < thr_t)) begin
        alarm_d[A_RPM_T] = 1'b0;
      end else begin
        alarm_d = alarm_q;
      end
      alarm_d[A_CYC_T] = uptime_x > CMP_W'(cyc_t_q);
      alarm_d[A_CYC_C] = uptime_x > CMP_W'(cyc_c_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_on_q <= 1'b0;
      start_q   <= '0;
      alarm_q   <= '0;
    end else if (step) begin
      pump_on_q <= pump_on_d;
      start_q   <= start_d;
      alarm_q   <= alarm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      running_q   <= pump_on_d;
      uptime_q    <= uptime_x[UPT_W-1:0];
      out_alarm_q <= alarm_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign running_o               = running_q;
  assign uptime_ms_o             = uptime_q;
  assign rpm_technical_alarm_o   = out_alarm_q[A_RPM_T];
  assign rpm_critical_alarm_o    = out_alarm_q[A_RPM_C];
  assign cycle_technical_alarm_o = out_alarm_q[A_CYC_T];
  assign cycle_critical_alarm_o  = out_alarm_q[A_CYC_C];

  // a stopped pump carries no alarm in the run state
  a_stopped_no_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pump_on_q |-> (alarm_q == '0))
    else $error("alarm flags set while pump stopped");

  // a stopped result reports zero uptime and no alarm
  a_stopped_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !running_q) |-> ((uptime_q == '0) && (out_alarm_q == '0)))
    else $error("stopped result with uptime or alarm");

  // an empty result register never stalls the input side
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  // run state only moves when an item passes into the result register
  a_state_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> ($stable(pump_on_q) && $stable(alarm_q)))
    else $error("run state changed without an item");

endmodule
